[rtl/core/btrf_pkg.sv]
// ---------------------------------------------------------------------------
// btrf_pkg
// shared types, constants and helpers of the bot token redaction filter
// ---------------------------------------------------------------------------
package btrf_pkg;

    localparam int unsigned ID_DIGITS_MAX_DEF  = 12;
    localparam int unsigned SECRET_LEN_MAX_DEF = 32;

    // counts of held bytes and results; covers the widest parameter range
    localparam int unsigned CNT_W = 7;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    localparam int unsigned REDACT_LEN = 10;

    localparam logic [3:0] MIN_ID_RST  = 4'd8;
    localparam logic [3:0] MAX_ID_RST  = 4'd12;
    localparam logic [5:0] MIN_SEC_RST = 6'd19;
    localparam logic [5:0] MIN_SEC_LO  = 6'd3;

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7a;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_DASH   = 8'h2d;

    typedef enum logic [1:0] {
        CFG_MIN_ID  = 2'd0,
        CFG_MAX_ID  = 2'd1,
        CFG_MIN_SEC = 2'd2
    } t_cfg_idx;

    // one command per accepted byte, front to back
    typedef struct packed {
        logic [7:0]       data;   // byte to hold or pass
        logic             push;   // hold data at the tail
        logic             lit;    // emit data after the releases
        logic             red;    // emit replacement, drop all held bytes
        logic [CNT_W-1:0] rel_n;  // held bytes released first
        logic [CNT_W-1:0] n_out;  // total beats of this command
    } t_cmd;

    function automatic logic [7:0] redact_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h5b;
            4'd1:    b = 8'h52;
            4'd2:    b = 8'h45;
            4'd3:    b = 8'h44;
            4'd4:    b = 8'h41;
            4'd5:    b = 8'h43;
            4'd6:    b = 8'h54;
            4'd7:    b = 8'h45;
            4'd8:    b = 8'h44;
            4'd9:    b = 8'h5d;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_tok(input logic [7:0] c);
        return is_digit(c) || ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
               ((c >= CH_LO_A) && (c <= CH_LO_Z)) || (c == CH_UNDER) || (c == CH_DASH);
    endfunction

endpackage

[rtl/core/bot_token_redaction_filter.sv]
// ---------------------------------------------------------------------------
// bot_token_redaction_filter
// byte stream filter that replaces bot tokens with "[REDACTED]"
// ---------------------------------------------------------------------------
// Input beats carry one text byte in tdata, tlast marks the end of text and
// flushes every held byte. Output beats carry one byte each; tlast is set on
// the final byte caused by an input beat. An input beat that only extends a
// candidate produces no output beat.
// The front stage classifies each accepted byte in the cycle it arrives and
// queues one command (four deep); the back stage issues a command's output
// beats in order, so plain text runs at one byte per cycle while the output
// queue has room. A mismatch, a flush or a replacement releases up to
// ID_DIGITS_MAX + SECRET_LEN_MAX + 1 beats; input stalls only once the
// command queue fills. Output passes through the issue stage and then the
// output queue once the back stage takes a command.
// Held bytes sit in a small memory addressed as a ring. Synchronous reset
// empties all queues and loads the register defaults (8, 12, 19). When the
// receiver stalls, four output beats buffer, then the back stage and then the
// input stall. The configuration channel is always ready; write it only idle.
// ---------------------------------------------------------------------------
module bot_token_redaction_filter #(
    parameter int unsigned ID_DIGITS_MAX  = btrf_pkg::ID_DIGITS_MAX_DEF,
    parameter int unsigned SECRET_LEN_MAX = btrf_pkg::SECRET_LEN_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,   // end_of_text
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast,   // last_of_run
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [5:0] i_cfg_data
);

    btrf_pkg::t_cmd wr_cmd, rd_cmd;
    logic           q_wr, q_full, q_rd, q_valid;

    assign o_cfg_ready = 1'b1;

    btrf_front #(
        .ID_DIGITS_MAX  (ID_DIGITS_MAX),
        .SECRET_LEN_MAX (SECRET_LEN_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_eot       (i_s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_wr      (q_wr),
        .o_cmd       (wr_cmd)
    );

    btrf_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_cmd   (wr_cmd),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_cmd   (rd_cmd)
    );

    btrf_back #(
        .ID_DIGITS_MAX  (ID_DIGITS_MAX),
        .SECRET_LEN_MAX (SECRET_LEN_MAX)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (rd_cmd),
        .o_q_rd    (q_rd),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

endmodule

[rtl/core/btrf_front.sv]
// ---------------------------------------------------------------------------
// btrf_front
// classifies each byte against the token pattern and issues one command
// ---------------------------------------------------------------------------
module btrf_front #(
    parameter int unsigned ID_DIGITS_MAX  = btrf_pkg::ID_DIGITS_MAX_DEF,
    parameter int unsigned SECRET_LEN_MAX = btrf_pkg::SECRET_LEN_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_eot,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [5:0]       i_cfg_data,
    input  logic             i_q_full,
    output logic             o_q_wr,
    output btrf_pkg::t_cmd   o_cmd
);

    localparam int unsigned CW = btrf_pkg::CNT_W;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_DIGITS  = 2'd1,
        PH_SECRET  = 2'd2,
        PH_SWALLOW = 2'd3
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_drl, n_drl;
    logic [CW-1:0] r_sl, n_sl;
    logic [CW-1:0] r_st, n_st;
    logic [3:0]    r_min_id, r_max_id;
    logic [5:0]    r_min_sec;

    btrf_pkg::t_cmd cmd;
    logic           accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_q_wr  = accept;
    assign o_cmd   = cmd;

    always_comb begin
        logic [CW-1:0] eff_max, eff_sec;
        logic [CW-1:0] d0, d1, d2, r1, r2, rel_a;
        logic          dig, tok, dig_path, idle_path;
        dig       = btrf_pkg::is_digit(i_byte);
        tok       = btrf_pkg::is_tok(i_byte);
        if (r_max_id == 4'd0) begin
            eff_max = CW'(1);
        end else if (CW'(r_max_id) > CW'(ID_DIGITS_MAX)) begin
            eff_max = CW'(ID_DIGITS_MAX);
        end else begin
            eff_max = CW'(r_max_id);
        end
        if (r_min_sec < btrf_pkg::MIN_SEC_LO) begin
            eff_sec = CW'(btrf_pkg::MIN_SEC_LO);
        end else if (CW'(r_min_sec) > CW'(SECRET_LEN_MAX)) begin
            eff_sec = CW'(SECRET_LEN_MAX);
        end else begin
            eff_sec = CW'(r_min_sec);
        end
        cmd       = '0;
        cmd.data  = i_byte;
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_drl     = r_drl;
        n_sl      = r_sl;
        n_st      = r_st;
        dig_path  = 1'b0;
        idle_path = 1'b0;
        d0        = r_drl;
        rel_a     = '0;
        d1        = '0;
        d2        = '0;
        r1        = '0;
        r2        = '0;
        case (r_phase)
            PH_IDLE: begin
                idle_path = 1'b1;
            end
            PH_DIGITS: begin
                dig_path = 1'b1;
            end
            PH_SECRET: begin
                if (tok && ((r_sl >= CW'(2)) || (i_byte == btrf_pkg::CH_UP_A))) begin
                    n_sl = r_sl + CW'(1);
                    n_st = dig ? r_st + CW'(1) : '0;
                    if (n_sl >= eff_sec) begin
                        cmd.red = 1'b1;
                        n_cnt   = '0;
                        n_drl   = '0;
                        n_sl    = '0;
                        n_st    = '0;
                        n_phase = PH_SWALLOW;
                    end else begin
                        cmd.push = 1'b1;
                        n_cnt    = r_cnt + CW'(1);
                    end
                end else begin
                    // keep the secret's trailing digits as a new candidate
                    rel_a = r_cnt - r_st;
                    n_sl  = '0;
                    n_st  = '0;
                    if (r_st != '0) begin
                        dig_path = 1'b1;
                        d0       = r_st;
                    end else begin
                        idle_path = 1'b1;
                    end
                end
            end
            PH_SWALLOW: begin
                if (!tok) begin
                    idle_path = 1'b1;
                end
            end
            default: begin
                idle_path = 1'b1;
            end
        endcase

        if (dig_path) begin
            r1 = (d0 > eff_max) ? d0 - eff_max : '0;
            d1 = d0 - r1;
            if (dig) begin
                d2        = d1 + CW'(1);
                r2        = (d2 > eff_max) ? CW'(1) : '0;
                cmd.rel_n = rel_a + r1 + r2;
                cmd.push  = 1'b1;
                n_drl     = d2 - r2;
                n_cnt     = d2 - r2;
                n_phase   = PH_DIGITS;
            end else if ((i_byte == btrf_pkg::CH_COLON) && (d1 >= CW'(r_min_id))) begin
                cmd.rel_n = rel_a + r1;
                cmd.push  = 1'b1;
                n_cnt     = d1 + CW'(1);
                n_drl     = d1;
                n_sl      = '0;
                n_st      = '0;
                n_phase   = PH_SECRET;
            end else begin
                cmd.rel_n = rel_a + d0;
                cmd.lit   = 1'b1;
                n_cnt     = '0;
                n_drl     = '0;
                n_sl      = '0;
                n_st      = '0;
                n_phase   = PH_IDLE;
            end
        end

        if (idle_path) begin
            cmd.rel_n = rel_a;
            n_sl      = '0;
            n_st      = '0;
            if (dig) begin
                cmd.push = 1'b1;
                n_cnt    = CW'(1);
                n_drl    = CW'(1);
                n_phase  = PH_DIGITS;
            end else begin
                cmd.lit  = 1'b1;
                n_cnt    = '0;
                n_drl    = '0;
                n_phase  = PH_IDLE;
            end
        end

        cmd.n_out = cmd.rel_n + CW'(cmd.lit) +
                    (cmd.red ? CW'(btrf_pkg::REDACT_LEN) : '0) +
                    (i_eot ? n_cnt : '0);
        if (i_eot) begin
            n_cnt   = '0;
            n_drl   = '0;
            n_sl    = '0;
            n_st    = '0;
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
            r_drl     <= '0;
            r_sl      <= '0;
            r_st      <= '0;
            r_min_id  <= btrf_pkg::MIN_ID_RST;
            r_max_id  <= btrf_pkg::MAX_ID_RST;
            r_min_sec <= btrf_pkg::MIN_SEC_RST;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_drl   <= n_drl;
                r_sl    <= n_sl;
                r_st    <= n_st;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    btrf_pkg::CFG_MIN_ID:  r_min_id  <= i_cfg_data[3:0];
                    btrf_pkg::CFG_MAX_ID:  r_max_id  <= i_cfg_data[3:0];
                    btrf_pkg::CFG_MIN_SEC: r_min_sec <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

[rtl/core/btrf_cmd_fifo.sv]
// ---------------------------------------------------------------------------
// btrf_cmd_fifo
// short command queue between front and back
// ---------------------------------------------------------------------------
module btrf_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  btrf_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_valid,
    output btrf_pkg::t_cmd o_cmd
);

    btrf_pkg::t_cmd                  r_mem [btrf_pkg::QDEPTH];
    logic [btrf_pkg::QPTR_W-1:0]     r_wp, r_rp;
    logic [btrf_pkg::QCNT_W-1:0]     r_cnt;

    assign o_full  = (r_cnt == btrf_pkg::QCNT_W'(btrf_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + btrf_pkg::QPTR_W'(1);
            end
            if (i_rd) begin
                r_rp <= r_rp + btrf_pkg::QPTR_W'(1);
            end
            r_cnt <= r_cnt + btrf_pkg::QCNT_W'(i_wr) - btrf_pkg::QCNT_W'(i_rd);
        end
    end

endmodule

[rtl/core/btrf_back.sv]
// ---------------------------------------------------------------------------
// btrf_back
// executes commands: holds bytes, releases them, sends the replacement
// ---------------------------------------------------------------------------
module btrf_back #(
    parameter int unsigned ID_DIGITS_MAX  = btrf_pkg::ID_DIGITS_MAX_DEF,
    parameter int unsigned SECRET_LEN_MAX = btrf_pkg::SECRET_LEN_MAX_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  btrf_pkg::t_cmd i_cmd,
    output logic           o_q_rd,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_data,
    output logic           o_last
);

    localparam int unsigned CW       = btrf_pkg::CNT_W;
    localparam int unsigned PEND_CAP = ID_DIGITS_MAX + SECRET_LEN_MAX;
    localparam int unsigned PTR_W    = $clog2(PEND_CAP + 1);
    localparam int unsigned DEPTH    = 2 ** PTR_W;

    logic [7:0]       r_mem [DEPTH];
    logic [7:0]       r_rd_data;
    logic [PTR_W-1:0] r_head, r_tail;
    logic [CW-1:0]    r_idx;

    // one-beat issue stage ahead of the output queue
    logic             r_s_valid, r_s_mem, r_s_last;
    logic [7:0]       r_s_byte;

    logic [7:0]                  r_of_data [btrf_pkg::QDEPTH];
    logic [btrf_pkg::QDEPTH-1:0] r_of_last;
    logic [btrf_pkg::QPTR_W-1:0] r_ofw, r_ofr;
    logic [btrf_pkg::QCNT_W-1:0] r_ocnt;

    logic       has_out, can_emit, step, first, last_beat, kind_lit, kind_red;
    logic       do_pop, we, byp, clear, o_pop;
    logic [7:0] s_byte;

    assign has_out   = (i_cmd.n_out != '0);
    assign can_emit  = (btrf_pkg::QCNT_W'(r_ocnt) + btrf_pkg::QCNT_W'(r_s_valid)) <
                       btrf_pkg::QCNT_W'(btrf_pkg::QDEPTH);
    assign step      = i_q_valid && (!has_out || can_emit);
    assign first     = (r_idx == '0);
    assign last_beat = (r_idx == i_cmd.n_out - CW'(1));
    assign kind_lit  = i_cmd.lit && (r_idx == i_cmd.rel_n);
    assign kind_red  = i_cmd.red && (r_idx < CW'(btrf_pkg::REDACT_LEN));
    assign do_pop    = step && has_out && !kind_lit && !kind_red;
    assign we        = step && first && i_cmd.push;
    assign clear     = step && first && i_cmd.red;
    // a byte pushed and released in the same cycle skips the memory
    assign byp       = we && do_pop && (r_head == r_tail);
    assign o_q_rd    = step && (!has_out || last_beat);
    assign s_byte    = kind_red ? btrf_pkg::redact_byte(r_idx[3:0]) : i_cmd.data;

    assign o_valid = (r_ocnt != '0);
    assign o_data  = r_of_data[r_ofr];
    assign o_last  = r_of_last[r_ofr];
    assign o_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_tail] <= i_cmd.data;
        end
        if (do_pop && !byp) begin
            r_rd_data <= r_mem[r_head];
        end
        r_s_byte <= s_byte;
        r_s_last <= last_beat;
        r_s_mem  <= do_pop && !byp;
        if (r_s_valid) begin
            r_of_data[r_ofw] <= r_s_mem ? r_rd_data : r_s_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_idx     <= '0;
            r_s_valid <= 1'b0;
            r_of_last <= '0;
            r_ofw     <= '0;
            r_ofr     <= '0;
            r_ocnt    <= '0;
        end else begin
            if (we) begin
                r_tail <= r_tail + PTR_W'(1);
            end
            if (clear) begin
                r_head <= r_tail;
            end else if (do_pop) begin
                r_head <= r_head + PTR_W'(1);
            end
            if (step) begin
                r_idx <= o_q_rd ? '0 : r_idx + CW'(1);
            end
            r_s_valid <= step && has_out;
            if (r_s_valid) begin
                r_of_last[r_ofw] <= r_s_last;
                r_ofw            <= r_ofw + btrf_pkg::QPTR_W'(1);
            end
            if (o_pop) begin
                r_ofr <= r_ofr + btrf_pkg::QPTR_W'(1);
            end
            r_ocnt <= r_ocnt + btrf_pkg::QCNT_W'(r_s_valid) - btrf_pkg::QCNT_W'(o_pop);
        end
    end

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PTR_W'(r_tail - r_head) <= PTR_W'(PEND_CAP))
        else $error("held bytes exceed capacity");

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= btrf_pkg::QCNT_W'(btrf_pkg::QDEPTH))
        else $error("output queue overflow");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && has_out) |-> (r_idx < i_cmd.n_out))
        else $error("beat index past command end");

    a_idx_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_rd |=> (r_idx == '0))
        else $error("beat index not cleared after command");

endmodule
